[rtl/owsp_pkg.sv]
// Shared types and constants of the omni wheel speed packer.
package owsp_pkg;

  // Default width of the velocity command fields.
  localparam int VEL_WIDTH = 16;
  localparam int NUM_WHEELS = 4;
  localparam int QBITS = 7;
  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS = 14;
  localparam int SPIN_SHIFT = 6;

  localparam logic [6:0] BYTE_FULL = 7'd127;
  localparam logic [15:0] DRIBBLE_ON_VALUE = 16'd255;
  // Dribble numerator: full byte times the dribble-on value.
  localparam logic [22:0] DRIBBLE_NUM = 23'd32385;

  // Register reset values.
  localparam logic [31:0] COEF_RESET = 32'd0;
  localparam logic [15:0] SPIN_RESET = 16'd256;
  localparam logic [15:0] MAX_SPEED_RESET = 16'd32767;
  localparam logic [7:0] ROBOT_ID_RESET = 8'd0;

  typedef enum logic [2:0] {
    REG_COEF_0    = 3'd0,
    REG_COEF_1    = 3'd1,
    REG_COEF_2    = 3'd2,
    REG_COEF_3    = 3'd3,
    REG_SPIN      = 3'd4,
    REG_MAX_SPEED = 3'd5,
    REG_ROBOT_ID  = 3'd6
  } owsp_reg_e;

  // Control that travels with each beat through the pipeline.
  typedef struct packed {
    logic                  valid;
    logic                  invalid;
    logic                  dribble;
    logic [NUM_WHEELS-1:0] pos;
    logic                  dzero;
  } owsp_ctl_t;

endpackage

[rtl/owsp_kin.sv]
// Kinematics stages: products, wheel speeds, largest magnitude and divider operands.
module owsp_kin #(
  parameter int VelWidth = owsp_pkg::VEL_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  owsp_pkg::owsp_ctl_t          ctl_i,
  input  logic signed [VelWidth-1:0]   vel_x_i,
  input  logic signed [VelWidth-1:0]   vel_y_i,
  input  logic signed [VelWidth-1:0]   vel_angular_i,
  input  logic [31:0]                  coef_i [owsp_pkg::NUM_WHEELS],
  input  logic [15:0]                  spin_i,
  input  logic [15:0]                  max_i,
  output owsp_pkg::owsp_ctl_t          ctl_o,
  output logic [VelWidth+30:0]         num_o [owsp_pkg::NUM_WHEELS],
  output logic [VelWidth+23:0]         den_o
);

  localparam int NW = owsp_pkg::NUM_WHEELS;
  localparam int PW = VelWidth + 16;
  localparam int AW = VelWidth + 17;
  localparam int SW = VelWidth + 24;
  localparam int NUMW = SW + owsp_pkg::QBITS;

  owsp_pkg::owsp_ctl_t ctl_a_q, ctl_b_q, ctl_c_q, ctl_d_q;
  owsp_pkg::owsp_ctl_t ctl_b_d, ctl_d_d;

  logic signed [PW-1:0] pc_q [NW];
  logic signed [PW-1:0] ps_q [NW];
  logic signed [AW-1:0] pa_q;

  logic signed [SW-1:0] spd [NW];
  logic [SW-1:0]        mag_b_d [NW];
  logic [SW-1:0]        mag_b_q [NW];
  logic [SW-1:0]        mag_c_q [NW];
  logic [SW-1:0]        lg01, lg23, lg_d, lg_q;
  logic [SW-1:0]        lim, den_d, den_q;
  logic [NUMW-1:0]      num_d [NW];
  logic [NUMW-1:0]      num_q [NW];

  // Speed sums and magnitudes.
  always_comb begin
    ctl_b_d = ctl_a_q;
    for (int i = 0; i < NW; i++) begin
      spd[i] = SW'(pc_q[i]) - SW'(ps_q[i]) + (SW'(pa_q) <<< owsp_pkg::SPIN_SHIFT);
      mag_b_d[i] = spd[i][SW-1] ? SW'(-spd[i]) : SW'(spd[i]);
      ctl_b_d.pos[i] = !spd[i][SW-1] && (spd[i] != '0);
    end
  end

  // Largest magnitude over the four wheels.
  always_comb begin
    lg01 = (mag_b_q[0] > mag_b_q[1]) ? mag_b_q[0] : mag_b_q[1];
    lg23 = (mag_b_q[2] > mag_b_q[3]) ? mag_b_q[2] : mag_b_q[3];
    lg_d = (lg01 > lg23) ? lg01 : lg23;
  end

  // Denominator is the larger of the largest speed and the scaled limit.
  always_comb begin
    lim   = SW'({max_i, {owsp_pkg::FRAC_BITS{1'b0}}});
    den_d = (lg_q > lim) ? lg_q : lim;
    ctl_d_d = ctl_c_q;
    ctl_d_d.dzero = (den_d == '0);
    for (int i = 0; i < NW; i++) begin
      num_d[i] = (NUMW'(mag_c_q[i]) << owsp_pkg::QBITS) - NUMW'(mag_c_q[i]);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
      ctl_d_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_b_d;
      ctl_c_q <= ctl_b_q;
      ctl_d_q <= ctl_d_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NW; i++) begin
        pc_q[i]    <= vel_y_i * $signed(coef_i[i][31:16]);
        ps_q[i]    <= vel_x_i * $signed(coef_i[i][15:0]);
        mag_b_q[i] <= mag_b_d[i];
        mag_c_q[i] <= mag_b_q[i];
        num_q[i]   <= num_d[i];
      end
      pa_q  <= vel_angular_i * $signed({1'b0, spin_i});
      lg_q  <= lg_d;
      den_q <= den_d;
    end
  end

  assign ctl_o = ctl_d_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

[rtl/owsp_div.sv]
// Pipelined restoring divider giving a seven-bit quotient, one bit per stage.
module owsp_div #(
  parameter int DenWidth = 40
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [DenWidth+owsp_pkg::QBITS-1:0]   num_i,
  input  logic [DenWidth-1:0]                   den_i,
  output logic [owsp_pkg::QBITS-1:0]            q_o
);

  localparam int STEPS = owsp_pkg::QBITS;
  localparam int NW = DenWidth + STEPS;

  logic [NW-1:0]       r_q [STEPS];
  logic [DenWidth-1:0] d_q [STEPS];
  logic [STEPS-1:0]    q_q [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    logic [NW-1:0]       r_in, cmp;
    logic [DenWidth-1:0] d_in;
    logic [STEPS-1:0]    q_in;
    logic                ge;

    // The first stage takes the operands, later stages take the previous stage.
    if (j == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[j-1];
      assign d_in = d_q[j-1];
      assign q_in = q_q[j-1];
    end

    // Each stage tries one shifted copy of the denominator.
    assign cmp = NW'(d_in) << (STEPS - 1 - j);
    assign ge  = (r_in >= cmp);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j] <= ge ? (r_in - cmp) : r_in;
        d_q[j] <= d_in;
        q_q[j] <= q_in | (STEPS'(ge) << (STEPS - 1 - j));
      end
    end
  end

  assign q_o = q_q[STEPS-1];

endmodule

[rtl/omni_wheel_speed_packer_core.sv]
// Top level of the four-wheel omni drive speed packer with its register file.
//
// Takes one velocity command beat per cycle and returns one frame beat per
// command once it has passed the kinematics stages (products, speed sums,
// largest magnitude, divider operands), the restoring division stages with
// one quotient bit per stage, and one output register. A sustained rate of
// one beat per cycle holds as long as the output is taken; a stall at the
// output holds the whole pipeline. Configuration writes are always accepted
// and should only be made while no command is in flight.
module omni_wheel_speed_packer_core #(
  parameter int VEL_WIDTH = owsp_pkg::VEL_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [VEL_WIDTH-1:0] vel_x_i,
  input  logic signed [VEL_WIDTH-1:0] vel_y_i,
  input  logic signed [VEL_WIDTH-1:0] vel_angular_i,
  input  logic                        dribble_on_i,
  input  logic                        command_invalid_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  frame_id_o,
  output logic signed [7:0]           wheel_byte_0_o,
  output logic signed [7:0]           wheel_byte_1_o,
  output logic signed [7:0]           wheel_byte_2_o,
  output logic signed [7:0]           wheel_byte_3_o,
  output logic [6:0]                  dribble_byte_o
);

  localparam int NW = owsp_pkg::NUM_WHEELS;
  localparam int DW = VEL_WIDTH + 24;
  localparam int STEPS = owsp_pkg::QBITS;

  logic [31:0] coef_q [NW];
  logic [15:0] spin_q, max_q;
  logic [7:0]  robot_id_q;

  owsp_pkg::owsp_ctl_t in_ctl, kin_ctl, out_ctl_q;
  owsp_pkg::owsp_ctl_t ctl_q [STEPS];
  logic [DW+STEPS-1:0] num [NW];
  logic [DW-1:0]       den;
  logic [STEPS-1:0]    q [NW];
  logic [STEPS-1:0]    dq;
  logic                en;
  logic signed [7:0]   wb_d [NW];
  logic signed [7:0]   wb_q [NW];
  logic [6:0]          drib_d, drib_q;

  // Register file writes.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) coef_q[i] <= owsp_pkg::COEF_RESET;
      spin_q     <= owsp_pkg::SPIN_RESET;
      max_q      <= owsp_pkg::MAX_SPEED_RESET;
      robot_id_q <= owsp_pkg::ROBOT_ID_RESET;
    end else if (cfg_valid_i) begin
      unique case (owsp_pkg::owsp_reg_e'(cfg_index_i))
        owsp_pkg::REG_COEF_0:    coef_q[0] <= cfg_data_i;
        owsp_pkg::REG_COEF_1:    coef_q[1] <= cfg_data_i;
        owsp_pkg::REG_COEF_2:    coef_q[2] <= cfg_data_i;
        owsp_pkg::REG_COEF_3:    coef_q[3] <= cfg_data_i;
        owsp_pkg::REG_SPIN:      spin_q <= cfg_data_i[15:0];
        owsp_pkg::REG_MAX_SPEED: max_q <= cfg_data_i[15:0];
        owsp_pkg::REG_ROBOT_ID:  robot_id_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances whenever the output register can move.
  assign en         = !out_ctl_q.valid || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    in_ctl         = '0;
    in_ctl.valid   = in_valid_i;
    in_ctl.invalid = command_invalid_i;
    in_ctl.dribble = dribble_on_i;
  end

  owsp_kin #(
    .VelWidth(VEL_WIDTH)
  ) u_kin (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .ctl_i         (in_ctl),
    .vel_x_i       (vel_x_i),
    .vel_y_i       (vel_y_i),
    .vel_angular_i (vel_angular_i),
    .coef_i        (coef_q),
    .spin_i        (spin_q),
    .max_i         (max_q),
    .ctl_o         (kin_ctl),
    .num_o         (num),
    .den_o         (den)
  );

  for (genvar i = 0; i < NW; i++) begin : g_lane
    owsp_div #(
      .DenWidth(DW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[i]),
      .den_i (den),
      .q_o   (q[i])
    );
  end

  // Dribble lane divides the fixed dribble numerator by the speed limit.
  owsp_div #(
    .DenWidth(16)
  ) u_div_drib (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (owsp_pkg::DRIBBLE_NUM),
    .den_i (max_q),
    .q_o   (dq)
  );

  // Control runs alongside the divider stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < STEPS; j++) ctl_q[j] <= '0;
      out_ctl_q <= '0;
    end else if (en) begin
      ctl_q[0] <= kin_ctl;
      for (int j = 1; j < STEPS; j++) ctl_q[j] <= ctl_q[j-1];
      out_ctl_q <= ctl_q[STEPS-1];
    end
  end

  // Sign, invalid and saturation handling of the frame bytes.
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      if (ctl_q[STEPS-1].invalid || ctl_q[STEPS-1].dzero) begin
        wb_d[i] = '0;
      end else if (ctl_q[STEPS-1].pos[i]) begin
        wb_d[i] = -$signed({1'b0, q[i]});
      end else begin
        wb_d[i] = $signed({1'b0, q[i]});
      end
    end
    if (ctl_q[STEPS-1].invalid || !ctl_q[STEPS-1].dribble) begin
      drib_d = '0;
    end else if (max_q < owsp_pkg::DRIBBLE_ON_VALUE) begin
      drib_d = owsp_pkg::BYTE_FULL;
    end else begin
      drib_d = dq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wb_q   <= wb_d;
      drib_q <= drib_d;
    end
  end

  assign out_valid_o    = out_ctl_q.valid;
  assign frame_id_o     = robot_id_q;
  assign wheel_byte_0_o = wb_q[0];
  assign wheel_byte_1_o = wb_q[1];
  assign wheel_byte_2_o = wb_q[2];
  assign wheel_byte_3_o = wb_q[3];
  assign dribble_byte_o = drib_q;

  // An invalid command leaves all frame bytes but the id zero.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ctl_q.invalid |->
      wheel_byte_0_o == 8'sd0 && wheel_byte_1_o == 8'sd0 &&
      wheel_byte_2_o == 8'sd0 && wheel_byte_3_o == 8'sd0 && dribble_byte_o == 7'd0)
    else $error("invalid command gave nonzero bytes");

  // A zero denominator never lets the divider's full quotient through.
  a_dzero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ctl_q.dzero |->
      wheel_byte_0_o == 8'sd0 && wheel_byte_1_o == 8'sd0 &&
      wheel_byte_2_o == 8'sd0 && wheel_byte_3_o == 8'sd0)
    else $error("zero denominator gave nonzero wheel bytes");

  // Wheel bytes stay within plus or minus full scale.
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> wheel_byte_0_o != -8'sd128 && wheel_byte_1_o != -8'sd128 &&
      wheel_byte_2_o != -8'sd128 && wheel_byte_3_o != -8'sd128)
    else $error("wheel byte out of range");

  // Input back-pressure only comes from a held output beat.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the omni wheel speed packer core.
module tb_top;

  localparam int LATENCY = 12;
  localparam int WATCHDOG_LIMIT = 20000;

  // One expected frame.
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] w0;
    logic [7:0] w1;
    logic [7:0] w2;
    logic [7:0] w3;
    logic [6:0] drib;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] vel_x_i = '0;
  logic signed [15:0] vel_y_i = '0;
  logic signed [15:0] vel_angular_i = '0;
  logic dribble_on_i = 1'b0;
  logic command_invalid_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] frame_id_o;
  logic signed [7:0] wheel_byte_0_o, wheel_byte_1_o, wheel_byte_2_o, wheel_byte_3_o;
  logic [6:0] dribble_byte_o;

  // Shadow copy of the register file.
  logic [31:0] coef_q[4];
  logic [15:0] spin_q;
  logic [15:0] max_speed_q;
  logic [7:0] robot_id_q;

  frame_t frame_queue[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit receiver_hold = 1'b0;

  always #5 clk_i = ~clk_i;

  omni_wheel_speed_packer_core u_dut (.*);

  // Computes the frame that one command must produce.
  function automatic frame_t predict_frame(logic signed [15:0] vx, logic signed [15:0] vy,
                                           logic signed [15:0] va, logic drib, logic inv);
    frame_t f;
    longint speed[4];
    longint c, s, mag, largest, denom, q;
    f = '0;
    f.id = robot_id_q;
    if (inv) return f;
    largest = 0;
    for (int i = 0; i < 4; i++) begin
      c = longint'($signed(coef_q[i][31:16]));
      s = longint'($signed(coef_q[i][15:0]));
      speed[i] = longint'(vy) * c - longint'(vx) * s + longint'(va) * longint'(spin_q) * 64;
      mag = speed[i] < 0 ? -speed[i] : speed[i];
      if (mag > largest) largest = mag;
    end
    denom = longint'(max_speed_q) << 14;
    if (largest > denom) denom = largest;
    for (int i = 0; i < 4; i++) begin
      q = 0;
      if (denom != 0) begin
        mag = speed[i] < 0 ? -speed[i] : speed[i];
        q = (127 * mag) / denom;
        if (q > 127) q = 127;
      end
      if (speed[i] > 0) q = -q;
      case (i)
        0: f.w0 = q[7:0];
        1: f.w1 = q[7:0];
        2: f.w2 = q[7:0];
        default: f.w3 = q[7:0];
      endcase
    end
    if (!drib) f.drib = '0;
    else if (max_speed_q < 16'd255) f.drib = owsp_pkg::BYTE_FULL;
    else f.drib = 7'((32385 / int'(max_speed_q)));
    return f;
  endfunction

  // Writes one register while the pipeline is empty.
  task automatic write_reg(owsp_pkg::owsp_reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      owsp_pkg::REG_SPIN: spin_q = data[15:0];
      owsp_pkg::REG_MAX_SPEED: max_speed_q = data[15:0];
      owsp_pkg::REG_ROBOT_ID: robot_id_q = data[7:0];
      default: coef_q[idx] = data;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one command beat; valid stays high across back-to-back beats.
  task automatic send_command(logic [15:0] vx, logic [15:0] vy, logic [15:0] va,
                              logic drib, logic inv);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    vel_x_i <= vx;
    vel_y_i <= vy;
    vel_angular_i <= va;
    dribble_on_i <= drib;
    command_invalid_i <= inv;
    do @(posedge clk_i); while (!in_ready_o);
    frame_queue.push_back(predict_frame(vx, vy, va, drib, inv));
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  // Waits until every frame has come back, then for the pipeline latency.
  task automatic drain();
    end_burst();
    while (frame_queue.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    for (int n = 0; n < count; n++)
      send_command(rand_vel(), rand_vel(), rand_vel(), 1'($urandom),
                   $urandom_range(0, 15) == 0);
  endtask

  // Extremes of every field, invalid commands and the dribble byte.
  task automatic test_directed();
    write_reg(owsp_pkg::REG_COEF_0, {16'sh2000, 16'sh2000});
    write_reg(owsp_pkg::REG_COEF_1, {16'sh8000, 16'sh7fff});
    write_reg(owsp_pkg::REG_COEF_2, {16'sh7fff, 16'sh8000});
    write_reg(owsp_pkg::REG_COEF_3, {16'shc000, 16'sh0000});
    write_reg(owsp_pkg::REG_ROBOT_ID, 32'hff);
    send_command(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_command(16'h7fff, 16'h7fff, 16'h7fff, 1'b1, 1'b0);
    send_command(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_command(16'h8000, 16'h7fff, 16'h0000, 1'b0, 1'b0);
    send_command(16'h7fff, 16'h8000, 16'h8000, 1'b1, 1'b1);
    send_command(16'hffff, 16'h0001, 16'hffff, 1'b0, 1'b1);
    send_command(16'h0010, 16'hfff0, 16'h0001, 1'b1, 1'b0);
    drain();
    // A zero limit takes the largest wheel to full scale, or to zero with no motion.
    write_reg(owsp_pkg::REG_MAX_SPEED, 32'd0);
    write_reg(owsp_pkg::REG_SPIN, 32'hffff);
    send_command(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_command(16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b0);
    send_command(16'h1234, 16'h8000, 16'h7fff, 1'b0, 1'b0);
    drain();
    // Dribble byte around the point where it stops saturating.
    write_reg(owsp_pkg::REG_MAX_SPEED, 32'd254);
    send_command(16'h0100, 16'h0100, 16'h0000, 1'b1, 1'b0);
    drain();
    write_reg(owsp_pkg::REG_MAX_SPEED, 32'd255);
    send_command(16'h0100, 16'h0100, 16'h0000, 1'b1, 1'b0);
    drain();
    write_reg(owsp_pkg::REG_MAX_SPEED, 32'd256);
    send_command(16'h0100, 16'h0100, 16'h0000, 1'b1, 1'b0);
    drain();
    write_reg(owsp_pkg::REG_MAX_SPEED, 32'd65535);
    write_reg(owsp_pkg::REG_SPIN, 32'd0);
    write_reg(owsp_pkg::REG_ROBOT_ID, 32'h00);
    send_command(16'h7fff, 16'h8000, 16'h7fff, 1'b1, 1'b0);
    send_command(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0);
    drain();
  endtask

  // Random commands under several register settings.
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 4; i++) write_reg(owsp_pkg::owsp_reg_e'(i), $urandom);
      write_reg(owsp_pkg::REG_SPIN,
                phase == 0 ? 32'hffff : phase == 1 ? 32'd0 : $urandom_range(0, 1024));
      write_reg(owsp_pkg::REG_MAX_SPEED, phase == 2 ? 32'd1 : phase == 3 ? 32'd65535 :
                $urandom_range(1, 40000));
      write_reg(owsp_pkg::REG_ROBOT_ID, $urandom);
      send_random(200);
      drain();
    end
  endtask

  // The receiver holds off while commands keep coming, filling the pipeline.
  task automatic test_backpressure();
    receiver_hold = 1'b1;
    fork
      send_random(60);
      begin
        repeat (200) @(negedge clk_i);
        receiver_hold = 1'b0;
      end
    join
    drain();
  endtask

  // Final stretch with no idling on either side.
  task automatic test_full_rate();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    send_random(120);
    drain();
  endtask

  // Receiver ready with random stall bursts.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (receiver_hold) out_ready_i <= 1'b0;
      else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end else out_ready_i <= 1'b1;
    end
  end

  // Compares each accepted frame with the oldest expectation.
  always @(posedge clk_i) begin
    frame_t exp_f;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_queue.size() == 0) begin
        $error("unexpected frame id %0h", frame_id_o);
        error_count++;
      end else begin
        exp_f = frame_queue.pop_front();
        if (frame_id_o !== exp_f.id) begin
          $error("frame_id exp %0h got %0h", exp_f.id, frame_id_o); error_count++;
        end
        if (wheel_byte_0_o !== exp_f.w0) begin
          $error("wheel_byte_0 exp %0h got %0h", exp_f.w0, wheel_byte_0_o); error_count++;
        end
        if (wheel_byte_1_o !== exp_f.w1) begin
          $error("wheel_byte_1 exp %0h got %0h", exp_f.w1, wheel_byte_1_o); error_count++;
        end
        if (wheel_byte_2_o !== exp_f.w2) begin
          $error("wheel_byte_2 exp %0h got %0h", exp_f.w2, wheel_byte_2_o); error_count++;
        end
        if (wheel_byte_3_o !== exp_f.w3) begin
          $error("wheel_byte_3 exp %0h got %0h", exp_f.w3, wheel_byte_3_o); error_count++;
        end
        if (dribble_byte_o !== exp_f.drib) begin
          $error("dribble_byte exp %0h got %0h", exp_f.drib, dribble_byte_o); error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) coef_q[i] = owsp_pkg::COEF_RESET;
    spin_q = owsp_pkg::SPIN_RESET;
    max_speed_q = owsp_pkg::MAX_SPEED_RESET;
    robot_id_q = owsp_pkg::ROBOT_ID_RESET;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Reset values first: a few commands before any write.
    send_random(10);
    drain();
    test_directed();
    test_random_settings();
    test_backpressure();
    test_full_rate();
    if (frame_queue.size() != 0) begin
      $error("%0d frames never arrived", frame_queue.size());
      error_count++;
    end
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
rtl/owsp_pkg.sv
rtl/owsp_kin.sv
rtl/owsp_div.sv
rtl/omni_wheel_speed_packer_core.sv
tb/tb_top.sv
